FILE: src/assert_macros.svh
// Shared assertion macros for the steering block checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset.
`define LSPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lsps assertion failed");

// Checked on every edge, reset included.
`define LSPS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lsps assertion failed");

`endif

FILE: src/lsps_pkg.sv
package lsps_pkg;

    localparam int SENSOR_BITS_DEF = 11;

    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_LIMIT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST_LIMIT = 1'd1;

    localparam logic [CFG_W-1:0] EDGE_LIMIT_RST    = 4'd5;
    localparam logic [CFG_W-1:0] PERSIST_LIMIT_RST = 4'd5;

    localparam int RUN_W = 5;
    localparam logic [RUN_W-1:0] RUN_MAX = 5'd31;

    localparam logic signed [7:0] FAULT_VALUE = 8'sd96;

    // Midpoint index to steer value; indexes past the table give zero.
    function automatic logic signed [7:0] steer_lut(input logic [5:0] idx);
        logic signed [7:0] v;
        unique case (idx)
            6'd0:    v = -8'sd127;
            6'd1:    v = -8'sd90;
            6'd2:    v = -8'sd75;
            6'd3:    v = -8'sd50;
            6'd4:    v = -8'sd25;
            6'd5:    v = 8'sd0;
            6'd6:    v = 8'sd25;
            6'd7:    v = 8'sd50;
            6'd8:    v = 8'sd75;
            6'd9:    v = 8'sd90;
            6'd10:   v = 8'sd127;
            default: v = 8'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/lsps_in_if.sv
interface lsps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] low_bits;
    logic [7:0] high_bits;

    modport source (output valid, output low_bits, output high_bits, input ready);
    modport sink   (input valid, input low_bits, input high_bits, output ready);
endinterface

FILE: src/lsps_out_if.sv
interface lsps_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] steer_value;
    logic              fault;

    modport source (output valid, output steer_value, output fault, input ready);
    modport sink   (input valid, input steer_value, input fault, output ready);
endinterface

FILE: src/line_sensor_position_steer.sv
// An accepted word goes through the input register, then the result register.
// Throughput: one word per cycle unless o_out stalls; the two registers form a
//   two-deep pipeline, so one new word is taken while a result waits.
// Reset: synchronous, active low; clears both valid flags and the bad-run
//   counter, and sets edge_limit and persist_limit to 5.
module line_sensor_position_steer #(
    parameter int SENSOR_BITS = lsps_pkg::SENSOR_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lsps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lsps_pkg::CFG_W-1:0]     i_cfg_data,
    lsps_in_if.sink                        i_in,
    lsps_out_if.source                     o_out
);

    // Bit position width and edge count width (count runs 0..SENSOR_BITS+1).
    localparam int PW = $clog2(SENSOR_BITS);
    localparam int EW = $clog2(SENSOR_BITS + 2);

    // ---------------- configuration ----------------
    logic [lsps_pkg::CFG_W-1:0] r_edge_limit;
    logic [lsps_pkg::CFG_W-1:0] r_persist_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_limit    <= lsps_pkg::EDGE_LIMIT_RST;
            r_persist_limit <= lsps_pkg::PERSIST_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lsps_pkg::CFG_EDGE_LIMIT:    r_edge_limit    <= i_cfg_data;
                lsps_pkg::CFG_PERSIST_LIMIT: r_persist_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic r_in_valid;
    logic r_out_valid;
    logic adv;      // result register can take a new word
    logic in_ready;

    assign adv      = !r_out_valid || o_out.ready;
    assign in_ready = !r_in_valid || adv;
    assign i_in.ready = in_ready;

    // ---------------- stage 1: input register ----------------
    logic [31:0]            raw_word;
    logic [SENSOR_BITS-1:0] r_reading;

    // Sensor word assembled from both bytes, cut (or zero-extended) to width.
    assign raw_word = {16'd0, i_in.high_bits, i_in.low_bits};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_reading <= raw_word[SENSOR_BITS-1:0];
        end
    end

    // ---------------- stage 2 logic ----------------
    logic [SENSOR_BITS-1:0] iso;        // lowest set bit isolated
    logic [SENSOR_BITS-1:0] low_mask;   // bits at or below the first one
    logic [SENSOR_BITS-1:0] zero_cand;  // clear bits above the first one
    logic [PW-1:0]          one_pos;
    logic [PW-1:0]          zero_pos;
    logic [SENSOR_BITS:0]   trans;      // transitions with zero padding
    logic [EW-1:0]          edges;
    logic [PW:0]            pos_sum;
    logic [PW-1:0]          mid;
    logic                   bad;
    logic                   flt;
    logic signed [7:0]      steer;
    logic [lsps_pkg::RUN_W-1:0] r_run;
    logic [lsps_pkg::RUN_W-1:0] n_run;

    // Empty reading: iso is zero, low_mask all ones, so zero_pos falls back
    // to the top bit and the midpoint lands at the center entry.
    assign iso       = r_reading & (~r_reading + SENSOR_BITS'(1));
    assign low_mask  = iso | (iso - SENSOR_BITS'(1));
    assign zero_cand = ~r_reading & ~low_mask;
    assign trans     = {r_reading, 1'b0} ^ {1'b0, r_reading};

    always_comb begin
        one_pos = '0;
        for (int i = SENSOR_BITS - 1; i >= 0; i--) begin
            if (r_reading[i]) begin
                one_pos = PW'(i);
            end
        end
    end

    always_comb begin
        zero_pos = PW'(SENSOR_BITS - 1);
        for (int i = SENSOR_BITS - 1; i >= 0; i--) begin
            if (zero_cand[i]) begin
                zero_pos = PW'(i);
            end
        end
    end

    always_comb begin
        edges = '0;
        for (int i = 0; i <= SENSOR_BITS; i++) begin
            edges = edges + EW'(trans[i]);
        end
    end

    assign pos_sum = {1'b0, one_pos} + {1'b0, zero_pos};
    assign mid     = pos_sum[PW:1];
    assign bad     = 6'(edges) > 6'(r_edge_limit);

    // Bad-run counter saturates; a good reading clears it.
    always_comb begin
        if (!bad) begin
            n_run = '0;
        end else if (r_run == lsps_pkg::RUN_MAX) begin
            n_run = r_run;
        end else begin
            n_run = r_run + {{(lsps_pkg::RUN_W - 1){1'b0}}, 1'b1};
        end
    end

    assign flt   = bad && (n_run > {1'b0, r_persist_limit});
    assign steer = flt ? lsps_pkg::FAULT_VALUE : lsps_pkg::steer_lut(6'(mid));

    // ---------------- stage 2: result register ----------------
    logic signed [7:0] r_steer;
    logic              r_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_run       <= '0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_run <= n_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid) begin
            r_steer <= steer;
            r_fault <= flt;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.steer_value = r_steer;
    assign o_out.fault       = r_fault;

endmodule

FILE: src/lsps_checker.sv
`include "assert_macros.svh"

module lsps_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic signed [7:0] i_steer_value,
    input logic              i_fault
);

    // Fault words always carry the error value.
    property p_fault_value;
        (i_out_valid && i_fault) |-> (i_steer_value == lsps_pkg::FAULT_VALUE);
    endproperty

    // The table never yields the error value, so it only shows with the flag.
    property p_no_stray_err;
        (i_out_valid && !i_fault) |-> (i_steer_value != lsps_pkg::FAULT_VALUE);
    endproperty

    // A stalled result word holds.
    property p_stall_hold;
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_steer_value) && $stable(i_fault));
    endproperty

    `LSPS_ASSERT(a_fault_value, i_clk, i_rst_n, p_fault_value)

    `LSPS_ASSERT(a_no_stray_err, i_clk, i_rst_n, p_no_stray_err)

    `LSPS_ASSERT(a_stall_hold, i_clk, i_rst_n, p_stall_hold)

    // Reset empties the result register.
    `LSPS_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind line_sensor_position_steer lsps_checker u_lsps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_steer_value(o_out.steer_value),
    .i_fault      (o_out.fault)
);

FILE: test/line_sensor_position_steer_test.sv
`timescale 1ns / 100ps

// Self-checking bench for the line sensor steering block.
// Directed probes first, then random phases under several limit settings,
// with bursty input traffic and a receiver that stalls on its own pattern.
module line_sensor_position_steer_test;

    localparam int READ_BITS  = lsps_pkg::SENSOR_BITS_DEF;
    localparam int WORDS_EACH = 195;     // minimum random words per phase
    localparam int IDLE_LIMIT = 4000;    // cycles with no handshake at all
    localparam int N_PROBES   = 24;
    localparam int N_PHASES   = 8;

    // Steer value per midpoint index, far right to far left.
    localparam logic signed [7:0] STEER_BY_MID [0:10] = '{
        -8'sd127, -8'sd90, -8'sd75, -8'sd50, -8'sd25, 8'sd0,
        8'sd25, 8'sd50, 8'sd75, 8'sd90, 8'sd127
    };

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PERIODIC,
        RDY_LONG
    } t_stall_mode;

    typedef struct packed {
        logic signed [7:0] steer;
        logic              fault;
    } t_steer_word;

    // One directed probe; typed rows carry their own expected word.
    typedef struct packed {
        logic [7:0]        low;
        logic [7:0]        high;
        logic              typed;
        logic signed [7:0] steer;
        logic              fault;
    } t_probe;

    typedef struct packed {
        logic [3:0]  edges;
        logic [3:0]  persist;
        t_stall_mode mode;
        logic [3:0]  gap_max;
    } t_phase;

    // Extremes of both fields, every table index, the empty reading, a
    // reading with no clear bit above its first one, ignored upper bits,
    // and a bad run that crosses the persistence limit at reset values.
    localparam t_probe PROBES [0:N_PROBES-1] = '{
        '{8'h00, 8'h00, 1'b1,  8'sd0,   1'b0},   // empty reading
        '{8'h01, 8'h00, 1'b1, -8'sd127, 1'b0},   // far right bit only
        '{8'h00, 8'h04, 1'b1,  8'sd127, 1'b0},   // far left bit only
        '{8'hFF, 8'h07, 1'b1,  8'sd0,   1'b0},   // all sensors lit
        '{8'h00, 8'hF8, 1'b1,  8'sd0,   1'b0},   // only ignored bits set
        '{8'hFF, 8'hFF, 1'b1,  8'sd0,   1'b0},   // everything set
        '{8'h02, 8'h00, 1'b0,  8'sd0,   1'b0},
        '{8'h04, 8'h00, 1'b0,  8'sd0,   1'b0},
        '{8'h08, 8'h00, 1'b0,  8'sd0,   1'b0},
        '{8'h10, 8'h00, 1'b0,  8'sd0,   1'b0},
        '{8'h20, 8'h00, 1'b0,  8'sd0,   1'b0},
        '{8'h40, 8'h00, 1'b0,  8'sd0,   1'b0},
        '{8'h80, 8'h00, 1'b0,  8'sd0,   1'b0},
        '{8'h00, 8'h01, 1'b0,  8'sd0,   1'b0},
        '{8'h00, 8'h02, 1'b0,  8'sd0,   1'b0},
        '{8'hC0, 8'h07, 1'b0,  8'sd0,   1'b0},   // no clear bit above
        '{8'h55, 8'h05, 1'b0,  8'sd0,   1'b0},   // alternating bits, bad run starts
        '{8'h55, 8'h05, 1'b0,  8'sd0,   1'b0},
        '{8'h55, 8'h05, 1'b0,  8'sd0,   1'b0},
        '{8'h55, 8'h05, 1'b0,  8'sd0,   1'b0},
        '{8'h55, 8'h05, 1'b0,  8'sd0,   1'b0},
        '{8'h55, 8'h05, 1'b1,  lsps_pkg::FAULT_VALUE, 1'b1}, // sixth bad: fault
        '{8'h55, 8'hFD, 1'b1,  lsps_pkg::FAULT_VALUE, 1'b1}, // still faulted
        '{8'h18, 8'h00, 1'b0,  8'sd0,   1'b0}    // clean reading clears run
    };

    // Limits per random phase; edge limits 0..12, persist limits 0..15.
    localparam t_phase PHASES [0:N_PHASES-1] = '{
        '{4'd0,  4'd0,  RDY_ALWAYS,   4'd0},   // no idling on either side
        '{4'd12, 4'd15, RDY_RANDOM,   4'd4},
        '{4'd3,  4'd2,  RDY_PERIODIC, 4'd3},
        '{4'd7,  4'd10, RDY_LONG,     4'd6},
        '{4'd1,  4'd15, RDY_RANDOM,   4'd0},
        '{4'd11, 4'd0,  RDY_PERIODIC, 4'd2},
        '{4'd5,  4'd5,  RDY_ALWAYS,   4'd5},
        '{4'd2,  4'd4,  RDY_LONG,     4'd1}
    };

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [lsps_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lsps_pkg::CFG_W-1:0]     cfg_data;

    lsps_in_if  in_if ();
    lsps_out_if out_if ();

    line_sensor_position_steer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Predictor state: shadow limits and run counter.
    logic [3:0]                 lim_edges   = lsps_pkg::EDGE_LIMIT_RST;
    logic [3:0]                 lim_persist = lsps_pkg::PERSIST_LIMIT_RST;
    logic [lsps_pkg::RUN_W-1:0] bad_run     = '0;

    t_steer_word pending_steer [$];   // expected words, oldest first
    int          failures    = 0;
    int          idle_cycles = 0;

    // Sideband travelling with each input word: typed expectation, if any.
    logic              row_typed;
    logic signed [7:0] row_steer;
    logic              row_fault;

    // Sender and receiver pacing.
    t_stall_mode stall_mode = RDY_ALWAYS;
    int          gap_max    = 0;
    int          burst_left = 0;
    int          stall_tick = 0;
    int          hold_left  = 0;

    always #1 i_clk = ~i_clk;

    function automatic int unsigned count_edges(input logic [READ_BITS-1:0] rd);
        int unsigned n;
        logic        prev;
        n    = 0;
        prev = 1'b0;
        for (int k = 0; k < READ_BITS; k++) begin
            if (rd[k] != prev) n++;
            prev = rd[k];
        end
        // zero pad above the top sensor
        if (prev) n++;
        return n;
    endfunction

    // Expected word for one reading; advances the bad-run counter.
    function automatic t_steer_word steer_for(input logic [READ_BITS-1:0] rd);
        int unsigned one_at;
        int unsigned zero_at;
        int unsigned mid;
        bit          seen_one;
        bit          seen_zero;
        t_steer_word w;
        one_at    = 0;
        zero_at   = READ_BITS - 1;
        seen_one  = 1'b0;
        seen_zero = 1'b0;
        for (int k = 0; k < READ_BITS; k++) begin
            if (!seen_one) begin
                if (rd[k]) begin
                    one_at   = k;
                    seen_one = 1'b1;
                end
            end else if (!rd[k] && !seen_zero) begin
                zero_at   = k;
                seen_zero = 1'b1;
            end
        end
        mid     = (one_at + zero_at) >> 1;
        w.steer = (mid <= 10) ? STEER_BY_MID[mid] : 8'sd0;
        w.fault = 1'b0;
        if (count_edges(rd) > lim_edges) begin
            // counter holds at its top value instead of wrapping
            if (bad_run != lsps_pkg::RUN_MAX) bad_run++;
            if (bad_run > lim_persist) begin
                w.steer = lsps_pkg::FAULT_VALUE;
                w.fault = 1'b1;
            end
        end else begin
            bad_run = '0;
        end
        return w;
    endfunction

    // A reading with more edges than the current limit, when one exists.
    function automatic logic [READ_BITS-1:0] bad_reading();
        logic [READ_BITS-1:0] rd;
        for (int t = 0; t < 40; t++) begin
            rd = READ_BITS'($urandom);
            if (count_edges(rd) > lim_edges) return rd;
        end
        return 11'h555;
    endfunction

    // Receiver: ready pattern chosen per phase, updated on the falling edge.
    always @(negedge i_clk) begin
        case (stall_mode)
            RDY_ALWAYS: begin
                out_if.ready <= 1'b1;
            end
            RDY_RANDOM: begin
                out_if.ready <= ($urandom_range(0, 3) != 0);
            end
            RDY_PERIODIC: begin
                out_if.ready <= ((stall_tick % 7) >= 3);
                stall_tick++;
            end
            default: begin
                // long runs of ready and stall
                if (hold_left == 0) begin
                    out_if.ready <= ~out_if.ready;
                    hold_left = $urandom_range(1, 12);
                end else begin
                    hold_left--;
                end
            end
        endcase
    end

    // Scoreboard. Results are checked before the same edge's input word is
    // queued, so a word can never be matched against itself.
    always @(posedge i_clk) begin
        t_steer_word want;
        t_steer_word got;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (pending_steer.size() == 0) begin
                    $display("%0t: unexpected word steer=%0d fault=%0b", $time,
                             out_if.steer_value, out_if.fault);
                    failures++;
                end else begin
                    want = pending_steer.pop_front();
                    if (out_if.steer_value !== want.steer) begin
                        $display("%0t: steer_value expected %0d actual %0d", $time,
                                 want.steer, out_if.steer_value);
                        failures++;
                    end
                    if (out_if.fault !== want.fault) begin
                        $display("%0t: fault expected %0b actual %0b", $time,
                                 want.fault, out_if.fault);
                        failures++;
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                got = steer_for({in_if.high_bits[2:0], in_if.low_bits});
                if (row_typed) begin
                    got.steer = row_steer;
                    got.fault = row_fault;
                end
                pending_steer.push_back(got);
            end
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("** line_sensor_position_steer: FAILED **");
                $finish;
            end
        end
    end

    // Present one word; entered and left on a falling edge. Valid stays high
    // within a burst, and may drop for a random gap between bursts.
    task automatic send_reading(input logic [7:0] low, input logic [7:0] high,
                                input logic typed, input logic signed [7:0] steer,
                                input logic fault);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_if.valid     <= 1'b1;
        in_if.low_bits  <= low;
        in_if.high_bits <= high;
        row_typed       <= typed;
        row_steer       <= steer;
        row_fault       <= fault;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(input logic [READ_BITS-1:0] rd);
        logic [4:0] pad;
        pad = 5'($urandom);
        send_reading(rd[7:0], {pad, rd[10:8]}, 1'b0, 8'sd0, 1'b0);
    endtask

    // Stop sending and let every expected word drain out.
    task automatic drain();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_steer.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Both registers written one after the other while the block is idle.
    task automatic program_limits(input logic [3:0] edges, input logic [3:0] persist);
        cfg_we    <= 1'b1;
        cfg_index <= lsps_pkg::CFG_EDGE_LIMIT;
        cfg_data  <= edges;
        @(negedge i_clk);
        cfg_index <= lsps_pkg::CFG_PERSIST_LIMIT;
        cfg_data  <= persist;
        @(negedge i_clk);
        cfg_we      <= 1'b0;
        lim_edges   = edges;
        lim_persist = persist;
    endtask

    initial begin
        int sent;
        int run_len;
        int kind;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = lsps_pkg::CFG_EDGE_LIMIT;
        cfg_data        = '0;
        in_if.valid     = 1'b0;
        in_if.low_bits  = '0;
        in_if.high_bits = '0;
        out_if.ready    = 1'b0;
        row_typed       = 1'b0;
        row_steer       = '0;
        row_fault       = 1'b0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed probes at the reset limits.
        stall_mode = RDY_RANDOM;
        gap_max    = 2;
        for (int p = 0; p < N_PROBES; p++) begin
            send_reading(PROBES[p].low, PROBES[p].high, PROBES[p].typed,
                         PROBES[p].steer, PROBES[p].fault);
        end
        drain();

        // Random phases: mostly bad runs of random length, some long enough to
        // pin the run counter, mixed with empty and arbitrary readings.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            program_limits(PHASES[ph].edges, PHASES[ph].persist);
            stall_mode = PHASES[ph].mode;
            gap_max    = int'(PHASES[ph].gap_max);
            sent       = 0;
            while (sent < WORDS_EACH) begin
                kind = $urandom_range(0, 9);
                if (kind <= 5) begin
                    if ($urandom_range(0, 4) == 0) begin
                        run_len = $urandom_range(33, 40);
                    end else begin
                        run_len = $urandom_range(1, PHASES[ph].persist + 3);
                    end
                    repeat (run_len) send_random(bad_reading());
                end else if (kind == 6) begin
                    run_len = 1;
                    send_random('0);
                end else begin
                    run_len = $urandom_range(1, 8);
                    repeat (run_len) send_random(READ_BITS'($urandom));
                end
                sent += run_len;
            end
            drain();
        end

        repeat (8) @(negedge i_clk);
        if (failures == 0) begin
            $display("** line_sensor_position_steer: PASSED **");
        end else begin
            $display("** line_sensor_position_steer: FAILED **");
        end
        $finish;
    end

endmodule
